>>> rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and codes of the scanline polygon fill block.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int DEF_MAX_VERTICES = 32;
	localparam int DEF_FRAC_BITS    = 4;
	localparam int MAX_RESULTS      = 32;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_FILL   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_WIN  = 2'd2;

	localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

	// one sorted crossing; dir 1 is +1, dir 0 is -1
	typedef struct packed {
		logic              valid;
		logic              dir;
		logic signed [11:0] x;
	} spf_item_t;

	// command broadcast to every cell of the sort chain
	typedef struct packed {
		logic              clear;
		logic              insert;
		logic              shift;
		logic              ins_dir;
		logic signed [11:0] ins_x;
	} spf_ctl_t;

endpackage

>>> rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/spf_cell.sv
// ----------------------------------------------------------------------------
// spf_cell
// One slot of the insertion-sort chain: holds a crossing, shifts right on
// insert when larger than the new x, shifts left on pop.
// ----------------------------------------------------------------------------
module spf_cell import spf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  spf_ctl_t  ctl,
	input  spf_item_t left,
	input  logic      left_gt,
	input  spf_item_t right,
	output spf_item_t q,
	output logic      gt
);

	spf_item_t item_q;

	assign q  = item_q;
	assign gt = item_q.valid && ($signed(item_q.x) > $signed(ctl.ins_x));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (ctl.clear) begin
			item_q.valid <= 1'b0;
		end else if (ctl.insert) begin
			if (left_gt) begin
				item_q <= left;
			end else if (left.valid && (gt || !item_q.valid)) begin
				item_q <= '{valid: 1'b1, dir: ctl.ins_dir, x: ctl.ins_x};
			end
		end else if (ctl.shift) begin
			item_q <= right;
		end
	end

endmodule

>>> rtl/spf_xcalc.sv
// ----------------------------------------------------------------------------
// spf_xcalc
// Edge/row intersection: two registered products, a sum, then a restoring
// divide one quotient bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module spf_xcalc import spf_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int DRW       = ((12 + FRAC_BITS) > 16 ? (12 + FRAC_BITS) : 16) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [15:0]    xi,
	input  logic signed [15:0]    yi,
	input  logic signed [15:0]    xj,
	input  logic signed [15:0]    yj,
	input  logic signed [DRW-1:0] rowf,
	output logic                  done,
	output logic signed [11:0]    x
);

	localparam int P1W  = 33;
	localparam int P2W  = DRW + 17;
	localparam int NUMW = (P1W > P2W ? P1W : P2W) + 1;
	localparam int DVW  = 17 + FRAC_BITS;
	localparam int CW   = $clog2(NUMW);

	localparam logic [2:0] X_IDLE = 3'd0;
	localparam logic [2:0] X_M1   = 3'd1;
	localparam logic [2:0] X_M2   = 3'd2;
	localparam logic [2:0] X_SUM  = 3'd3;
	localparam logic [2:0] X_DIV  = 3'd4;
	localparam logic [2:0] X_OUT  = 3'd5;

	logic [2:0]            state_q;
	logic signed [16:0]    dy_q, dx_q;
	logic signed [15:0]    xi_q;
	logic signed [DRW-1:0] dr_q;
	logic signed [P1W-1:0] p1_q;
	logic signed [P2W-1:0] p2_q;
	logic [NUMW-1:0]       mag_q;
	logic [DVW-1:0]        dvs_q;
	logic [DVW:0]          rem_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;

	logic signed [NUMW-1:0] num;
	logic [16:0]            absdy;
	logic [DVW:0]           rem_sh;
	logic                   qbit;

	assign num    = NUMW'(p1_q) + NUMW'(p2_q);
	assign absdy  = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
	assign rem_sh = {rem_q[DVW-1:0], mag_q[NUMW-1]};
	assign qbit   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
		end else begin
			case (state_q)
				X_IDLE: if (start) state_q <= X_M1;
				X_M1:   state_q <= X_M2;
				X_M2:   state_q <= X_SUM;
				X_SUM:  state_q <= X_DIV;
				X_DIV:  if (cnt_q == CW'(0)) state_q <= X_OUT;
				X_OUT:  state_q <= X_IDLE;
				default: state_q <= X_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			X_IDLE: begin
				dy_q <= 17'(yj) - 17'(yi);
				dx_q <= 17'(xj) - 17'(xi);
				xi_q <= xi;
				dr_q <= rowf - DRW'(yi);
			end
			X_M1: p1_q <= P1W'(xi_q) * P1W'(dy_q);
			X_M2: p2_q <= P2W'(dr_q) * P2W'(dx_q);
			X_SUM: begin
				neg_q <= num[NUMW-1] ^ dy_q[16];
				mag_q <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
				dvs_q <= DVW'(absdy) << FRAC_BITS;
				rem_q <= '0;
				cnt_q <= CW'(NUMW - 1);
			end
			X_DIV: begin
				rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
				mag_q <= {mag_q[NUMW-2:0], qbit};
				cnt_q <= cnt_q - CW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		if (neg_q && (mag_q > NUMW'(2048))) begin
			x = -12'sd2048;
		end else if (!neg_q && (mag_q > NUMW'(2047))) begin
			x = 12'sd2047;
		end else if (neg_q) begin
			x = 12'(-mag_q[11:0]);
		end else begin
			x = mag_q[11:0];
		end
	end

	assign done = (state_q == X_OUT);

endmodule

>>> rtl/scanline_polygon_fill_nonzero.sv
// ----------------------------------------------------------------------------
// scanline_polygon_fill_nonzero
// Polygon store and nonzero-winding row filler emitting clipped spans.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_ready): func, vertex_x, vertex_y, row.
//    One transaction at a time; req_ready is high when the sequencer is idle
//    and the response register is free or being drained.
//  - Response channel (rsp_valid/rsp_ready): one transaction per result; the
//    last one of a request has last set. Append, clear and out-of-window
//    rows answer in the cycle after acceptance.
//  - Fill sequence: fetch the closing vertex, test each edge against the row,
//    run the bit-serial divider for each crossing edge, then pop the sort
//    chain and emit the final result.
//  - Crossings go into a chain of MAX_VERTICES sort cells, one insert per
//    crossing as the divider finishes.
//  - A stalled receiver holds the sequencer at the next span it must emit.
//  - Reset clears the vertex count, the chain, the window to 0..2047 and the
//    response valid flag. Vertex memory is not cleared.
//  - The APB port writes the clip registers at byte addresses 0,4,8,12.
// ----------------------------------------------------------------------------
module scanline_polygon_fill_nonzero import spf_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         func,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [11:0] row,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [11:0] span_row,
	output logic signed [11:0] span_start,
	output logic signed [11:0] span_end,
	output logic               span_valid,
	output logic [1:0]         status,
	output logic               last
);

	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int WW  = $clog2(MAX_VERTICES + 1) + 1;
	localparam int DRW = ((12 + FRAC_BITS) > 16 ? (12 + FRAC_BITS) : 16) + 1;
	localparam int SCW = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREV = 3'd1;
	localparam logic [2:0] S_EDGE = 3'd2;
	localparam logic [2:0] S_CALC = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	// clip window
	logic signed [11:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

	logic [2:0]            state_q;
	logic [VCW-1:0]        vcnt_q;
	logic [VCW-1:0]        vlast;
	logic [AW-1:0]         i_q;
	logic signed [11:0]    row_q;
	logic signed [DRW-1:0] rowf_q;
	logic signed [15:0]    prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic                  dir_q;
	logic signed [WW-1:0]  w_q;
	logic [SCW-1:0]        span_cnt_q;
	logic signed [11:0]    pend_s_q, pend_e_q;

	// response register
	logic               rsp_valid_q, span_valid_q, last_q;
	logic signed [11:0] span_row_q, span_start_q, span_end_q;
	logic [1:0]         status_q;

	logic req_acc, out_free, cfg_wr;

	// vertex memory
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic          ram_we;

	// edge test
	logic signed [15:0]    rd_x, rd_y;
	logic signed [DRW-1:0] yi_e, yj_e, rowf_n;
	logic                  cross_up, cross_dn;

	// crossing unit
	logic               xstart, xdone;
	logic signed [11:0] xval;

	// sort chain
	spf_ctl_t  ctl;
	spf_item_t cq  [MAX_VERTICES];
	logic      cgt [MAX_VERTICES];
	spf_item_t c0, c1;

	// scan step
	logic signed [WW-1:0] wn;
	logic signed [11:0]   a_cl, b_cl;
	logic                 new_span, touch, need_emit, scan_adv, scan_end;

	assign req_acc  = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	assign rsp_valid  = rsp_valid_q;
	assign span_row   = span_row_q;
	assign span_start = span_start_q;
	assign span_end   = span_end_q;
	assign span_valid = span_valid_q;
	assign status     = status_q;
	assign last       = last_q;

	always_comb begin
		case (paddr[3:2])
			REG_CLIP_LEFT:   prdata = 32'(clip_left_q);
			REG_CLIP_TOP:    prdata = 32'(clip_top_q);
			REG_CLIP_RIGHT:  prdata = 32'(clip_right_q);
			REG_CLIP_BOTTOM: prdata = 32'(clip_bottom_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= 12'sd0;
			clip_top_q    <= 12'sd0;
			clip_right_q  <= 12'sd2047;
			clip_bottom_q <= 12'sd2047;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CLIP_LEFT:   clip_left_q   <= pwdata[11:0];
				REG_CLIP_TOP:    clip_top_q    <= pwdata[11:0];
				REG_CLIP_RIGHT:  clip_right_q  <= pwdata[11:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// memory addressing: last vertex first, then 0, 1, 2 ...
	assign vlast  = vcnt_q - VCW'(1);
	assign ram_we = req_acc && (func == FUNC_APPEND) && (vcnt_q != VCW'(MAX_VERTICES));

	always_comb begin
		case (state_q)
			S_IDLE:  raddr = vlast[AW-1:0];
			S_PREV:  raddr = '0;
			default: raddr = i_q + AW'(1);
		endcase
	end

	spf_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vcnt_q[AW-1:0]),
		.wdata ({vertex_x, vertex_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_x   = rdata[31:16];
	assign rd_y   = rdata[15:0];
	assign yi_e   = DRW'(rd_y);
	assign yj_e   = DRW'(prev_y_q);
	assign rowf_n = DRW'(row) <<< FRAC_BITS;
	assign cross_up = (yi_e < rowf_q) && (yj_e >= rowf_q);
	assign cross_dn = (yj_e < rowf_q) && (yi_e >= rowf_q);
	assign xstart   = (state_q == S_EDGE) && (cross_up || cross_dn);

	spf_xcalc #(.FRAC_BITS(FRAC_BITS), .DRW(DRW)) u_xcalc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xstart),
		.xi     (rd_x),
		.yi     (rd_y),
		.xj     (prev_x_q),
		.yj     (prev_y_q),
		.rowf   (rowf_q),
		.done   (xdone),
		.x      (xval)
	);

	// sort chain; the head cell sees a valid, never-greater sentinel
	assign ctl.clear   = req_acc && (func == FUNC_FILL);
	assign ctl.insert  = (state_q == S_CALC) && xdone;
	assign ctl.shift   = scan_adv;
	assign ctl.ins_dir = dir_q;
	assign ctl.ins_x   = xval;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		spf_item_t lft, rgt;
		logic      lgt;
		if (g == 0) begin : g_head
			assign lft = '{valid: 1'b1, dir: 1'b0, x: 12'sd0};
			assign lgt = 1'b0;
		end else begin : g_body
			assign lft = cq[g-1];
			assign lgt = cgt[g-1];
		end
		if (g == MAX_VERTICES - 1) begin : g_tail
			assign rgt = '0;
		end else begin : g_mid
			assign rgt = cq[g+1];
		end
		spf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left    (lft),
			.left_gt (lgt),
			.right   (rgt),
			.q       (cq[g]),
			.gt      (cgt[g])
		);
	end

	// scan of the two head cells
	assign c0 = cq[0];
	assign c1 = cq[1];
	assign wn = c0.dir ? (w_q + WW'(1)) : (w_q - WW'(1));
	assign a_cl = ($signed(c0.x) < clip_left_q) ? clip_left_q : $signed(c0.x);
	assign b_cl = ($signed(c1.x) > clip_right_q) ? clip_right_q : $signed(c1.x);
	assign new_span = ($signed(c1.x) > clip_left_q) && (a_cl < b_cl);
	assign touch    = (span_cnt_q != SCW'(0)) && (pend_e_q == a_cl);

	always_comb begin
		scan_end  = 1'b0;
		need_emit = 1'b0;
		scan_adv  = 1'b0;
		if (state_q == S_SCAN) begin
			if (!c0.valid) begin
				scan_end = 1'b1;
			end else if (wn == WW'(0)) begin
				scan_adv = 1'b1;
			end else if (!c1.valid || ($signed(c0.x) >= clip_right_q)) begin
				scan_end = 1'b1;
			end else begin
				need_emit = new_span && !touch && (span_cnt_q != SCW'(0))
					&& (span_cnt_q < SCW'(MAX_RESULTS));
				scan_adv = !need_emit || out_free;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
			span_cnt_q  <= '0;
			i_q         <= '0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						rsp_valid_q  <= 1'b1;
						span_row_q   <= 12'sd0;
						span_start_q <= 12'sd0;
						span_end_q   <= 12'sd0;
						span_valid_q <= 1'b0;
						status_q     <= ST_OK;
						last_q       <= 1'b1;
						case (func)
							FUNC_APPEND: begin
								if (vcnt_q == VCW'(MAX_VERTICES)) begin
									status_q <= ST_FULL;
								end else begin
									vcnt_q <= vcnt_q + VCW'(1);
								end
							end
							FUNC_CLEAR: vcnt_q <= '0;
							FUNC_FILL: begin
								if ((row < clip_top_q) || (row >= clip_bottom_q)) begin
									span_row_q <= row;
									status_q   <= ST_WIN;
								end else begin
									rsp_valid_q <= 1'b0;
									row_q       <= row;
									rowf_q      <= rowf_n;
									w_q         <= '0;
									span_cnt_q  <= '0;
									i_q         <= '0;
									state_q     <= (vcnt_q == VCW'(0)) ? S_SCAN : S_PREV;
								end
							end
							default: ;
						endcase
					end
				end
				S_PREV: begin
					prev_x_q <= rd_x;
					prev_y_q <= rd_y;
					state_q  <= S_EDGE;
				end
				S_EDGE: begin
					cur_x_q <= rd_x;
					cur_y_q <= rd_y;
					dir_q   <= cross_up;
					if (cross_up || cross_dn) begin
						state_q <= S_CALC;
					end else begin
						prev_x_q <= rd_x;
						prev_y_q <= rd_y;
						i_q      <= i_q + AW'(1);
						if (i_q == vlast[AW-1:0]) state_q <= S_SCAN;
					end
				end
				S_CALC: begin
					if (xdone) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						i_q      <= i_q + AW'(1);
						state_q  <= (i_q == vlast[AW-1:0]) ? S_SCAN : S_EDGE;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end else if (scan_adv) begin
						w_q <= wn;
						if (wn != WW'(0) && new_span) begin
							if (touch) begin
								pend_e_q <= b_cl;
							end else if (span_cnt_q < SCW'(MAX_RESULTS)) begin
								pend_s_q   <= a_cl;
								pend_e_q   <= b_cl;
								span_cnt_q <= span_cnt_q + SCW'(1);
							end
						end
						if (need_emit) begin
							rsp_valid_q  <= 1'b1;
							span_row_q   <= row_q;
							span_start_q <= pend_s_q;
							span_end_q   <= pend_e_q;
							span_valid_q <= 1'b1;
							status_q     <= ST_OK;
							last_q       <= 1'b0;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						span_row_q   <= row_q;
						status_q     <= ST_OK;
						last_q       <= 1'b1;
						span_valid_q <= (span_cnt_q != SCW'(0));
						span_start_q <= (span_cnt_q != SCW'(0)) ? pend_s_q : 12'sd0;
						span_end_q   <= (span_cnt_q != SCW'(0)) ? pend_e_q : 12'sd0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_vcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VCW'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_span_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && span_valid_q |-> status_q == ST_OK)
		else $error("span result with non-ok status");

	a_span_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		span_cnt_q <= SCW'(MAX_RESULTS))
		else $error("span count overflow");

	a_xdone_calc: assert property (@(posedge clk) disable iff (!arst_n)
		xdone |-> state_q == S_CALC)
		else $error("crossing result outside calc state");
`endif

endmodule

>>> bench/tb_scanline_polygon_fill_nonzero.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanline_polygon_fill_nonzero
// Self-checking bench for the nonzero-winding scanline filler: vertex lists
// and row fills are driven on the request channel, every span transaction is
// checked against an in-bench predictor, and the clip window is reprogrammed
// over APB between phases with different idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_scanline_polygon_fill_nonzero;
	import spf_pkg::*;

	// func code 3 is unused by the block but must still be answered
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int N_VERT     = DEF_MAX_VERTICES;
	localparam int FRAC       = DEF_FRAC_BITS;
	localparam int IDLE_LIMIT = 20000;   // longer than a full-store fill plus the hold-off
	localparam int HOLD_LEN   = 3000;

	// one response transaction
	typedef struct {
		logic signed [11:0] srow;
		logic signed [11:0] first;
		logic signed [11:0] stop;
		logic               valid;
		logic [1:0]         stat;
		logic               lst;
	} span_t;

	// ------------------------------------------------------------------------
	// Span predictor and scoreboard
	// ------------------------------------------------------------------------
	class span_scoreboard;
		longint clip_l, clip_t, clip_r, clip_b;
		longint vx[N_VERT];
		longint vy[N_VERT];
		int     nvert;
		span_t  spans_due[$];
		int     errors;

		function new();
			clip_l = 0; clip_t = 0; clip_r = 2047; clip_b = 2047;
			nvert = 0;
			errors = 0;
		endfunction

		function void set_clip(logic [1:0] idx, logic signed [11:0] val);
			case (idx)
				REG_CLIP_LEFT:   clip_l = val;
				REG_CLIP_TOP:    clip_t = val;
				REG_CLIP_RIGHT:  clip_r = val;
				REG_CLIP_BOTTOM: clip_b = val;
				default: ;
			endcase
		endfunction

		function void push(longint r, longint a, longint b, bit v, logic [1:0] st, bit l);
			span_t s;
			s.srow = r[11:0]; s.first = a[11:0]; s.stop = b[11:0];
			s.valid = v; s.stat = st; s.lst = l;
			spans_due = {spans_due, s};
		endfunction

		// crossings of every edge, stable sort, winding walk, clip, merge
		function void predict_fill(longint r);
			longint rowf, xs[N_VERT], ss[MAX_RESULTS], se[MAX_RESULTS];
			longint x, num, dy, a, b;
			int ds[N_VERT];
			int nc, ns, j, p, d, w, dd;
			rowf = r * (64'sd1 <<< FRAC);
			nc = 0; ns = 0; w = 0;
			if (r < clip_t || r >= clip_b) begin
				push(r, 0, 0, 0, ST_WIN, 1);
				return;
			end
			j = nvert ? nvert - 1 : 0;
			for (int i = 0; i < nvert; i++) begin
				d = 0;
				if (vy[i] < rowf && vy[j] >= rowf) d = 1;
				else if (vy[j] < rowf && vy[i] >= rowf) d = -1;
				if (d != 0) begin
					dy = vy[j] - vy[i];
					num = vx[i] * dy + (rowf - vy[i]) * (vx[j] - vx[i]);
					x = num / (dy * (64'sd1 <<< FRAC));
					if (x < -2048) x = -2048;
					if (x > 2047) x = 2047;
					xs[nc] = x; ds[nc] = d; nc++;
				end
				j = i;
			end
			for (int i = 1; i < nc; i++) begin
				x = xs[i]; dd = ds[i]; p = i;
				while (p > 0 && xs[p-1] > x) begin
					xs[p] = xs[p-1]; ds[p] = ds[p-1]; p--;
				end
				xs[p] = x; ds[p] = dd;
			end
			for (int i = 0; i < nc; i++) begin
				w += ds[i];
				if (w == 0) continue;
				if (i + 1 >= nc) break;
				a = xs[i]; b = xs[i+1];
				if (a >= clip_r) break;
				if (b > clip_l) begin
					if (a < clip_l) a = clip_l;
					if (b > clip_r) b = clip_r;
					if (a < b) begin
						if (ns > 0 && se[ns-1] == a) se[ns-1] = b;
						else if (ns < MAX_RESULTS) begin
							ss[ns] = a; se[ns] = b; ns++;
						end
					end
				end
			end
			if (ns == 0) push(r, 0, 0, 0, ST_OK, 1);
			for (int k = 0; k < ns; k++) push(r, ss[k], se[k], 1, ST_OK, k == ns - 1);
		endfunction

		// accepted request transaction
		function void note_request(logic [1:0] f, logic signed [15:0] x,
		                           logic signed [15:0] y, logic signed [11:0] r);
			case (f)
				FUNC_APPEND: begin
					if (nvert >= N_VERT) push(0, 0, 0, 0, ST_FULL, 1);
					else begin
						vx[nvert] = x; vy[nvert] = y; nvert++;
						push(0, 0, 0, 0, ST_OK, 1);
					end
				end
				FUNC_FILL: predict_fill(r);
				FUNC_CLEAR: begin
					nvert = 0;
					push(0, 0, 0, 0, ST_OK, 1);
				end
				default: push(0, 0, 0, 0, ST_OK, 1);
			endcase
		endfunction

		// accepted response transaction
		function void check_result(span_t got);
			span_t exp_s;
			if (spans_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected span row=%0d start=%0d end=%0d",
					         got.srow, got.first, got.stop);
				return;
			end
			exp_s = spans_due.pop_front();
			if (got.srow !== exp_s.srow || got.first !== exp_s.first ||
			    got.stop !== exp_s.stop || got.valid !== exp_s.valid ||
			    got.stat !== exp_s.stat || got.lst !== exp_s.lst) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: exp row=%0d [%0d,%0d) v=%0b st=%0d last=%0b",
					         exp_s.srow, exp_s.first, exp_s.stop, exp_s.valid,
					         exp_s.stat, exp_s.lst);
					$display("       got row=%0d [%0d,%0d) v=%0b st=%0d last=%0b",
					         got.srow, got.first, got.stop, got.valid,
					         got.stat, got.lst);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic               clk, arst_n;
	logic               psel, penable, pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               req_valid, req_ready;
	logic [1:0]         func;
	logic signed [15:0] vertex_x, vertex_y;
	logic signed [11:0] row;
	logic               rsp_valid, rsp_ready;
	logic signed [11:0] span_row, span_start, span_end;
	logic               span_valid;
	logic [1:0]         status;
	logic               last;

	scanline_polygon_fill_nonzero dut (.*);

	span_scoreboard sb;
	int  send_idle, recv_idle;     // idle chance in percent
	bit  hold_rsp;                 // request for a long receiver hold-off
	int  idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Response side: random back-pressure plus one long hold-off on demand
	// ------------------------------------------------------------------------
	initial begin
		span_t got;
		int hold_left;
		hold_left = 0;
		rsp_ready = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				got.srow = span_row; got.first = span_start; got.stop = span_end;
				got.valid = span_valid; got.stat = status; got.lst = last;
				sb.check_result(got);
			end
			if (hold_rsp) begin
				hold_left = HOLD_LEN;
				hold_rsp = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------
	task automatic send_req(logic [1:0] f, logic signed [15:0] x,
	                        logic signed [15:0] y, logic signed [11:0] r);
		if ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_valid <= 1'b1;
		func      <= f;
		vertex_x  <= x;
		vertex_y  <= y;
		row       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(f, x, y, r);
	endtask

	// vertex given in whole pixels plus a random fraction
	task automatic add_vertex(int px, int py);
		send_req(FUNC_APPEND, 16'(px * 16 + $urandom_range(15)),
		         16'(py * 16 + $urandom_range(15)), 0);
	endtask

	task automatic write_clip(logic [1:0] idx, logic signed [11:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_clip(idx, val);
	endtask

	// drop valid, let every expected span arrive, then cover fill latency
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.spans_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_window(int l, int t, int r, int b);
		drain();
		write_clip(REG_CLIP_LEFT, 12'(l));
		write_clip(REG_CLIP_TOP, 12'(t));
		write_clip(REG_CLIP_RIGHT, 12'(r));
		write_clip(REG_CLIP_BOTTOM, 12'(b));
	endtask

	// mostly well-formed polygons followed by fills; some raw noise
	task automatic random_traffic(int n_items);
		int sent, nv, nf;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 75) begin
				send_req(FUNC_CLEAR, 16'($urandom), 16'($urandom), 12'($urandom));
				nv = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
				for (int i = 0; i < nv; i++)
					add_vertex($urandom_range(0, 400) - 80, $urandom_range(0, 400) - 80);
				nf = $urandom_range(2, 5);
				for (int i = 0; i < nf; i++)
					send_req(FUNC_FILL, 16'($urandom), 16'($urandom),
					         12'($urandom_range(0, 420) - 90));
				sent += 1 + nv + nf;
			end else begin
				send_req(2'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		req_valid = 0; func = FUNC_APPEND; vertex_x = '0; vertex_y = '0; row = '0;
		hold_rsp = 0; idle_cycles = 0;
		send_idle = 29; recv_idle = 63;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default window: empty store, unused code, out-of-window rows
		send_req(FUNC_FILL, 0, 0, 12'sd5);
		send_req(FUNC_NOP, 16'hFFFF, 16'hFFFF, 12'hFFF);
		send_req(FUNC_FILL, 0, 0, -12'sd1);
		send_req(FUNC_FILL, 0, 0, 12'sd2047);
		send_req(FUNC_FILL, 0, 0, -12'sd2048);
		// square 1..10
		send_req(FUNC_APPEND, 16'sd16, 16'sd16, 0);
		send_req(FUNC_APPEND, 16'sd160, 16'sd16, 0);
		send_req(FUNC_APPEND, 16'sd160, 16'sd160, 0);
		send_req(FUNC_APPEND, 16'sd16, 16'sd160, 0);
		send_req(FUNC_FILL, 0, 0, 12'sd5);
		send_req(FUNC_FILL, 0, 0, 12'sd1);
		send_req(FUNC_FILL, 0, 0, 12'sd10);
		// self-overlapping star: nonzero winding fills the core
		send_req(FUNC_CLEAR, 0, 0, 0);
		send_req(FUNC_APPEND, 16'sd800, 16'sd0, 0);
		send_req(FUNC_APPEND, 16'sd1280, 16'sd1600, 0);
		send_req(FUNC_APPEND, 16'sd0, 16'sd560, 0);
		send_req(FUNC_APPEND, 16'sd1600, 16'sd560, 0);
		send_req(FUNC_APPEND, 16'sd320, 16'sd1600, 0);
		send_req(FUNC_FILL, 0, 0, 12'sd50);
		// coordinate extremes; a three-vertex list
		send_req(FUNC_CLEAR, 0, 0, 0);
		send_req(FUNC_APPEND, -16'sd32768, -16'sd32768, 0);
		send_req(FUNC_APPEND, 16'sd32767, 16'sd32767, 0);
		send_req(FUNC_APPEND, -16'sd32768, 16'sd32767, 0);
		send_req(FUNC_FILL, 0, 0, 12'sd100);
		send_req(FUNC_FILL, 0, 0, 12'sd2046);

		// widest window, sender idles
		set_window(-2048, -2048, 2047, 2047);
		send_idle = 29; recv_idle = 63;
		send_req(FUNC_FILL, 0, 0, -12'sd2048);
		send_req(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < 34; i++) add_vertex(i * 7 - 100, (i % 2) * 200 - 100);
		send_req(FUNC_FILL, 0, 0, 12'sd0);
		random_traffic(15);

		// narrow window, receiver idles
		set_window(20, 10, 200, 150);
		send_idle = 63; recv_idle = 29;
		random_traffic(15);

		// reversed and degenerate windows, then one with a long receiver hold-off
		set_window(100, -30, 5, 300);
		random_traffic(5);
		set_window(-2048, 2046, -2048, -2048);
		send_req(FUNC_FILL, 0, 0, 12'sd2046);
		set_window(2047, -50, 2047, 350);
		send_req(FUNC_FILL, 0, 0, 12'sd60);
		set_window(-40, -60, 250, 320);
		send_idle = 0; recv_idle = 0;
		hold_rsp = 1;
		random_traffic(15);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.spans_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
